FILE: rtl/core/spqe_pkg.sv
// Package for the sorted priority queue with erase.
// Item types, request and status codes, sequencer states and compare result.
// No dependencies.
`default_nettype none

package spqe_pkg;

  typedef enum logic [1:0] {
    REQ_PUSH      = 2'd0,
    REQ_ERASE     = 2'd1,
    REQ_ERASE_LIM = 2'd2,
    REQ_CLEAR     = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_MATCH = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_RD,
    S_PUSH_EV,
    S_PUSH_WR,
    S_ERA_RD,
    S_ERA_EV,
    S_HEAD_RD,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] state_id;
    logic [31:0] f_key;
    logic [31:0] g_cost;
    logic [31:0] limit_cost;
  } req_t;

  typedef struct packed {
    logic [15:0] head_id;
    logic        head_valid;
    logic [6:0]  entry_count;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic gt;   // stored key above new key (push) or stored cost above limit
    logic hit;  // id matches and, for the limited erase, cost is above limit
  } cmp_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/spqe_if.sv
// Valid/ready channels for request and response items.
// Depends on spqe_pkg for the payload types.
`default_nettype none

interface spqe_req_if;
  import spqe_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface spqe_rsp_if;
  import spqe_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sorted_priority_queue_with_erase_core.sv
// Sorted priority queue with erase: sequencer, entry RAM and response register.
// Depends on spqe_pkg, spqe_if, spqe_ram and spqe_cmp.
//
// Min-ordered open list of up to QUEUE_DEPTH entries (id, key, cost) kept
// sorted by ascending key in one RAM, with equal keys in arrival order.
// One request item is taken at a time and every request gives one response
// item with the head id, head-valid flag, count and status. The RAM has one
// read and one write port and a registered read, so the sequencer visits each
// entry in a read state followed by an evaluate state. A push moves each entry
// with a larger key up one slot, from the end down, then writes the new entry;
// an erase scans all stored entries and closes the gap behind the first match;
// a clear, a refused push or an erase on an empty queue reads the head directly.
// A new request is taken while the previous response still waits; a second
// finished response holds the sequencer until the first one is taken.
`default_nettype none

module sorted_priority_queue_with_erase_core #(
  parameter int QUEUE_DEPTH = 64,
  parameter int ID_BITS     = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spqe_req_if.sink   req_i,
  spqe_rsp_if.source rsp_o
);
  import spqe_pkg::*;

  localparam int AddrW = $clog2(QUEUE_DEPTH);
  localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int WordW = ID_BITS + 64;

  state_e state_q, state_d;

  logic [CntW-1:0]    fill_q, fill_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               found_q, found_d;
  status_e            status_q, status_d;
  req_type_e          op_type_q;
  logic [ID_BITS-1:0] op_id_q;
  logic [31:0]        op_key_q, op_cost_q, op_limit_q;

  logic               rsp_valid_q, rsp_valid_d;
  rsp_t               rsp_q;
  logic               rsp_load;

  logic               accept;
  logic [31:0]        id_ext, head_ext, fill_ext;
  logic [CntW-1:0]    cnt_m1;

  logic               ram_we, ram_re;
  logic [AddrW-1:0]   ram_waddr, ram_raddr;
  logic [WordW-1:0]   ram_wdata, ram_rdata;
  logic               wr_new;

  logic [ID_BITS-1:0] rd_id;
  logic [31:0]        rd_key, rd_cost;
  cmp_res_t           cmp;

  assign accept  = req_i.valid && req_i.ready;
  assign id_ext  = 32'(req_i.payload.state_id);
  assign cnt_m1  = cnt_q - CntW'(1);

  assign rd_id   = ram_rdata[WordW-1 -: ID_BITS];
  assign rd_key  = ram_rdata[63:32];
  assign rd_cost = ram_rdata[31:0];

  spqe_ram #(
    .WIDTH (WordW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  spqe_cmp #(
    .ID_BITS (ID_BITS)
  ) u_cmp (
    .is_push_i  (op_type_q == REQ_PUSH),
    .limited_i  (op_type_q == REQ_ERASE_LIM),
    .rd_id_i    (rd_id),
    .rd_key_i   (rd_key),
    .rd_cost_i  (rd_cost),
    .op_id_i    (op_id_q),
    .op_key_i   (op_key_q),
    .op_limit_i (op_limit_q),
    .res_o      (cmp)
  );

  assign ram_wdata = wr_new ? {op_id_q, op_key_q, op_cost_q} : ram_rdata;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_type_e'(req_i.payload.req_type))
            REQ_PUSH: begin
              if (fill_q == CntW'(QUEUE_DEPTH)) begin
                state_d = S_HEAD_RD;
              end else if (fill_q == '0) begin
                state_d = S_PUSH_WR;
              end else begin
                state_d = S_PUSH_RD;
              end
            end
            REQ_ERASE, REQ_ERASE_LIM: begin
              state_d = (fill_q == '0) ? S_HEAD_RD : S_ERA_RD;
            end
            default: state_d = S_HEAD_RD;
          endcase
        end
      end
      S_PUSH_RD: state_d = S_PUSH_EV;
      S_PUSH_EV: begin
        if (!cmp.gt) begin
          state_d = S_HEAD_RD;
        end else if (cnt_q == CntW'(1)) begin
          state_d = S_PUSH_WR;
        end else begin
          state_d = S_PUSH_RD;
        end
      end
      S_PUSH_WR: state_d = S_HEAD_RD;
      S_ERA_RD:  state_d = S_ERA_EV;
      S_ERA_EV:  state_d = (cnt_q == fill_q - CntW'(1)) ? S_HEAD_RD : S_ERA_RD;
      S_HEAD_RD: state_d = S_OUT;
      S_OUT:     state_d = (!rsp_valid_q || rsp_o.ready) ? S_IDLE : S_OUT;
      default:   state_d = S_IDLE;
    endcase
  end

  // sequencer outputs and datapath updates
  always_comb begin
    fill_d    = fill_q;
    cnt_d     = cnt_q;
    found_d   = found_q;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = cnt_q[AddrW-1:0];
    ram_raddr = cnt_q[AddrW-1:0];
    wr_new    = 1'b0;
    rsp_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_DONE;
          found_d  = 1'b0;
          case (req_type_e'(req_i.payload.req_type))
            REQ_PUSH: begin
              cnt_d = fill_q;
              if (fill_q == CntW'(QUEUE_DEPTH)) begin
                status_d = ST_FULL;
              end
            end
            REQ_ERASE, REQ_ERASE_LIM: begin
              cnt_d = '0;
              if (fill_q == '0) begin
                status_d = ST_NO_MATCH;
              end
            end
            default: fill_d = '0;
          endcase
        end
      end
      S_PUSH_RD: begin
        ram_re    = 1'b1;
        ram_raddr = cnt_m1[AddrW-1:0];
      end
      S_PUSH_EV: begin
        ram_we = 1'b1;
        if (cmp.gt) begin
          // move the larger entry up one slot
          cnt_d = cnt_m1;
        end else begin
          wr_new = 1'b1;
          fill_d = fill_q + CntW'(1);
        end
      end
      S_PUSH_WR: begin
        ram_we = 1'b1;
        wr_new = 1'b1;
        fill_d = fill_q + CntW'(1);
      end
      S_ERA_RD: begin
        ram_re = 1'b1;
      end
      S_ERA_EV: begin
        cnt_d = cnt_q + CntW'(1);
        if (found_q) begin
          // close the gap behind the removed entry
          ram_we    = 1'b1;
          ram_waddr = cnt_m1[AddrW-1:0];
        end else if (cmp.hit) begin
          found_d = 1'b1;
        end
        if (cnt_q == fill_q - CntW'(1)) begin
          if (found_q || cmp.hit) begin
            fill_d = fill_q - CntW'(1);
          end else begin
            status_d = ST_NO_MATCH;
          end
        end
      end
      S_HEAD_RD: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      S_OUT: begin
        rsp_load = !rsp_valid_q || rsp_o.ready;
      end
      default: ;
    endcase
  end

  assign head_ext = 32'(rd_id);
  assign fill_ext = 32'(fill_q);

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      status_q    <= ST_DONE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      found_q     <= found_d;
      status_q    <= status_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // hold the request operands for the whole operation and load the response register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_type_q  <= req_type_e'(req_i.payload.req_type);
      op_id_q    <= id_ext[ID_BITS-1:0];
      op_key_q   <= req_i.payload.f_key;
      op_cost_q  <= req_i.payload.g_cost;
      op_limit_q <= req_i.payload.limit_cost;
    end
    if (rsp_load) begin
      rsp_q.head_id     <= (fill_q != '0) ? head_ext[15:0] : 16'd0;
      rsp_q.head_valid  <= (fill_q != '0);
      rsp_q.entry_count <= fill_ext[6:0];
      rsp_q.status      <= status_q;
    end
  end

  assign req_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

endmodule

`default_nettype wire

FILE: rtl/core/spqe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module spqe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/spqe_cmp.sv
// Shared compare unit: one 32-bit magnitude compare plus id match.
// Depends on spqe_pkg for the result struct.
`default_nettype none

module spqe_cmp #(
  parameter int ID_BITS = 16
) (
  input  wire logic               is_push_i,
  input  wire logic               limited_i,
  input  wire logic [ID_BITS-1:0] rd_id_i,
  input  wire logic [31:0]        rd_key_i,
  input  wire logic [31:0]        rd_cost_i,
  input  wire logic [ID_BITS-1:0] op_id_i,
  input  wire logic [31:0]        op_key_i,
  input  wire logic [31:0]        op_limit_i,
  output spqe_pkg::cmp_res_t      res_o
);
  import spqe_pkg::*;

  logic [31:0] opa, opb;
  logic        gt;

  // push compares keys, erase compares cost against the limit
  assign opa = is_push_i ? rd_key_i : rd_cost_i;
  assign opb = is_push_i ? op_key_i : op_limit_i;
  assign gt  = opa > opb;

  assign res_o.gt  = gt;
  assign res_o.hit = (rd_id_i == op_id_i) && (!limited_i || gt);

endmodule

`default_nettype wire

FILE: bench/spqe_open_list_checker.sv
`timescale 1ns / 100ps
// Checker for the sorted priority queue. It mirrors the open list from the
// accepted request items and compares each response item with the predicted one.
// Depends on spqe_pkg.

module spqe_open_list_checker #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic           req_ready_i,
  input  spqe_pkg::req_t req_payload_i,
  input  logic           rsp_valid_i,
  input  logic           rsp_ready_i,
  input  spqe_pkg::rsp_t rsp_payload_i,
  output int             mismatches_o,
  output int             awaited_o
);
  import spqe_pkg::*;

  typedef struct {
    logic [15:0] id;
    logic [31:0] key;
    logic [31:0] cost;
  } open_entry_t;

  open_entry_t open_list[$];
  rsp_t        awaited_rsp[$];
  rsp_t        want;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    if (mismatches_o < 40) begin
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, exp_val);
    end
    mismatches_o++;
  endtask

  // Apply one request to the mirrored list and return the response it gives.
  function automatic rsp_t predict_response(input req_t r);
    open_entry_t fresh;
    rsp_t        res;
    status_e     st;
    int          pos;
    bit          limited;
    st = ST_DONE;
    case (req_type_e'(r.req_type))
      REQ_PUSH: begin
        if (open_list.size() >= QUEUE_DEPTH) begin
          st = ST_FULL;
        end else begin
          pos = open_list.size();
          // insert before the first strictly larger key: ties keep arrival order
          for (int k = 0; k < open_list.size(); k++) begin
            if (open_list[k].key > r.f_key) begin
              pos = k;
              break;
            end
          end
          fresh.id   = r.state_id;
          fresh.key  = r.f_key;
          fresh.cost = r.g_cost;
          open_list.insert(pos, fresh);
        end
      end
      REQ_ERASE, REQ_ERASE_LIM: begin
        limited = (req_type_e'(r.req_type) == REQ_ERASE_LIM);
        st = ST_NO_MATCH;
        // a matching id whose cost is not above the limit stays; keep scanning
        for (int k = 0; k < open_list.size(); k++) begin
          if (open_list[k].id == r.state_id &&
              (!limited || open_list[k].cost > r.limit_cost)) begin
            open_list.delete(k);
            st = ST_DONE;
            break;
          end
        end
      end
      default: open_list.delete();
    endcase
    res.head_valid  = (open_list.size() > 0);
    res.head_id     = (open_list.size() > 0) ? open_list[0].id : 16'h0000;
    res.entry_count = 7'(open_list.size());
    res.status      = st;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_list.delete();
      awaited_rsp.delete();
      awaited_o = 0;
    end else begin
      // a response can never belong to a request accepted at the same edge
      if (rsp_valid_i && rsp_ready_i) begin
        if (awaited_rsp.size() == 0) begin
          report_mismatch("response item with none awaited", 32'(rsp_payload_i.head_id), '0);
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp_payload_i.head_id !== want.head_id)
            report_mismatch("head_id", 32'(rsp_payload_i.head_id), 32'(want.head_id));
          if (rsp_payload_i.head_valid !== want.head_valid)
            report_mismatch("head_valid", 32'(rsp_payload_i.head_valid),
                            32'(want.head_valid));
          if (rsp_payload_i.entry_count !== want.entry_count)
            report_mismatch("entry_count", 32'(rsp_payload_i.entry_count),
                            32'(want.entry_count));
          if (rsp_payload_i.status !== want.status)
            report_mismatch("status", 32'(rsp_payload_i.status), 32'(want.status));
        end
      end
      if (req_valid_i && req_ready_i) begin
        awaited_rsp.insert(awaited_rsp.size(), predict_response(req_payload_i));
      end
      awaited_o = awaited_rsp.size();
    end
  end

endmodule

FILE: bench/tb_sorted_priority_queue_with_erase_core.sv
`timescale 1ns / 100ps
// Testbench top for the sorted priority queue core: clock, reset, request
// stimulus, response stalls and the verdict.
// Depends on spqe_pkg, spqe_if, the core and spqe_open_list_checker.

module tb_sorted_priority_queue_with_erase_core;
  import spqe_pkg::*;

  localparam int QUEUE_DEPTH  = 64;
  localparam int ID_BITS      = 16;
  localparam int RANDOM_BLOCKS = 14;
  localparam int BLOCK_ITEMS   = 100;
  localparam int DRAIN_CYCLES  = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        steady;
  int          mismatches;
  int          awaited;
  logic [15:0] id_pool [16];

  spqe_req_if req_if ();
  spqe_rsp_if rsp_if ();

  sorted_priority_queue_with_erase_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  spqe_open_list_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_if.valid),
    .req_ready_i   (req_if.ready),
    .req_payload_i (req_if.payload),
    .rsp_valid_i   (rsp_if.valid),
    .rsp_ready_i   (rsp_if.ready),
    .rsp_payload_i (rsp_if.payload),
    .mismatches_o  (mismatches),
    .awaited_o     (awaited)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Response side: stall now and then, never during the steady stretch.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= rst_ni && (steady || ($urandom_range(0, 99) >= 6));
    end
  end

  initial begin
    #(10_000_000);
    $display("tb_sorted_priority_queue_with_erase_core: FAIL");
    $finish;
  end

  function automatic req_t build_request(input req_type_e kind, input logic [15:0] id,
                                         input logic [31:0] key, input logic [31:0] cost,
                                         input logic [31:0] limit);
    req_t r;
    r.req_type   = kind;
    r.state_id   = id;
    r.f_key      = key;
    r.g_cost     = cost;
    r.limit_cost = limit;
    return r;
  endfunction

  // Mostly ids from a small pool so erases hit and duplicates pile up.
  function automatic logic [15:0] pick_id();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return id_pool[$urandom_range(0, 15)];
  endfunction

  // Call at a rising edge; returns at the edge where the item is accepted.
  task automatic send_item(input req_t item);
    while (!steady && ($urandom_range(0, 99) < 6)) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= item;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  initial begin
    int          push_pct;
    int          pick;
    logic [31:0] key;
    logic [31:0] cost;
    rst_ni         = 1'b0;
    steady         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    foreach (id_pool[i]) id_pool[i] = 16'($urandom);
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty queue, ties, extremes, duplicate ids, limited erase scan.
    send_item(build_request(REQ_CLEAR, 16'($urandom), $urandom, $urandom, $urandom));
    send_item(build_request(REQ_ERASE, 16'h0000, $urandom, $urandom, $urandom));
    send_item(build_request(REQ_ERASE_LIM, 16'hFFFF, $urandom, $urandom, 32'h0));
    send_item(build_request(REQ_PUSH, 16'h1234, 32'h0005_0000, 32'd10, $urandom));
    send_item(build_request(REQ_PUSH, 16'h1234, 32'h0005_0000, 32'd100, $urandom));
    send_item(build_request(REQ_PUSH, 16'h0000, 32'h0, 32'h0, $urandom));
    send_item(build_request(REQ_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom));
    send_item(build_request(REQ_PUSH, 16'h0ABC, 32'h0005_0000, 32'd7, $urandom));
    send_item(build_request(REQ_ERASE_LIM, 16'h1234, $urandom, $urandom, 32'd50));
    send_item(build_request(REQ_ERASE_LIM, 16'h1234, $urandom, $urandom, 32'd50));
    send_item(build_request(REQ_ERASE_LIM, 16'hFFFF, $urandom, $urandom, 32'hFFFF_FFFF));
    send_item(build_request(REQ_ERASE_LIM, 16'hFFFF, $urandom, $urandom, 32'hFFFF_FFFE));
    send_item(build_request(REQ_ERASE, 16'h0000, $urandom, $urandom, $urandom));
    send_item(build_request(REQ_ERASE, 16'h5555, $urandom, $urandom, $urandom));
    send_item(build_request(REQ_PUSH, 16'hAAAA, 32'h0, 32'hFFFF_FFFF, $urandom));
    send_item(build_request(REQ_PUSH, 16'h5555, 32'h0, 32'd1, $urandom));
    send_item(build_request(REQ_ERASE, 16'h1234, $urandom, $urandom, $urandom));
    send_item(build_request(REQ_CLEAR, 16'($urandom), $urandom, $urandom, $urandom));
    send_item(build_request(REQ_PUSH, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, $urandom));
    send_item(build_request(REQ_ERASE, 16'hFFFF, $urandom, $urandom, $urandom));

    // Random: blocks that fill to full, hover, and drain in turn.
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      steady <= (blk == 6 || blk == 7);
      if (blk == 4) begin
        // hold off until every awaited response is back
        req_if.valid <= 1'b0;
        @(negedge clk_i);
        while (awaited != 0) @(negedge clk_i);
        @(posedge clk_i);
      end
      push_pct = (blk % 3 == 0) ? 98 : (blk % 3 == 1) ? 55 : 20;
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 2))
          0:       key = $urandom_range(0, 7) << 16;
          1:       key = $urandom_range(0, 255);
          default: key = $urandom;
        endcase
        cost = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 15);
        if (pick < push_pct) begin
          send_item(build_request(REQ_PUSH, pick_id(), key, cost, $urandom));
        end else if (pick == 99 && push_pct < 98) begin
          send_item(build_request(REQ_CLEAR, 16'($urandom), key, cost, $urandom));
        end else if (pick[0]) begin
          send_item(build_request(REQ_ERASE, pick_id(), key, $urandom, $urandom));
        end else begin
          send_item(build_request(REQ_ERASE_LIM, pick_id(), key, $urandom, cost));
        end
      end
    end

    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (awaited != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_sorted_priority_queue_with_erase_core: PASS");
    end else begin
      $display("tb_sorted_priority_queue_with_erase_core: FAIL");
    end
    $finish;
  end

endmodule
